// ===== design/ddd_pkg.sv =====
// Shared types and constants for the date difference core.
package ddd_pkg;

	localparam int YEAR_W     = 14;
	localparam int MONTH_W    = 4;
	localparam int DAY_W      = 5;
	localparam int COUNT_W    = 22;
	localparam int SERIAL_W   = 23;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 24;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
	localparam logic [DAY_W-1:0]   DAY_LEAP  = 5'd29;

	// year / 100 by reciprocal: q = (y * 655) >> 16, low by at most one
	localparam int RECIP_100   = 655;
	localparam int RECIP_SHIFT = 16;
	localparam int PROD_W      = 24;
	localparam int Q100_W      = 8;
	localparam int R100_W      = 7;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic               ok;     // month and day in range, Feb allows 29
		logic               feb29;  // valid only if the year is leap
	} ddd_date_t;

	typedef struct packed {
		ddd_date_t start_date;
		ddd_date_t end_date;
		logic      include_end;
	} ddd_item_t;

endpackage

// ===== design/ddd_front.sv =====
// Front end: takes input requests, unpacks and range-checks both dates.
module ddd_front (
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [ddd_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                           q_full,
	output logic                           q_push,
	output ddd_pkg::ddd_item_t             q_item
);
	import ddd_pkg::*;

	function automatic logic [DAY_W-1:0] month_len_max(input logic [MONTH_W-1:0] m);
		logic [DAY_W-1:0] len;
		case (m)
			4'd2:                      len = 5'd29;
			4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
			4'd1, 4'd3, 4'd5, 4'd7,
			4'd8, 4'd10, 4'd12:        len = 5'd31;
			default:                   len = 5'd0;
		endcase
		return len;
	endfunction

	function automatic ddd_date_t classify(input logic [YEAR_W-1:0] y,
			input logic [MONTH_W-1:0] m, input logic [DAY_W-1:0] d);
		ddd_date_t r;
		r.year  = y;
		r.month = m;
		r.day   = d;
		r.ok    = (m >= MONTH_JAN) && (m <= MONTH_DEC) && (d != '0) &&
			(d <= month_len_max(m));
		r.feb29 = (m == MONTH_FEB) && (d == DAY_LEAP);
		return r;
	endfunction

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	always_comb begin
		q_item.start_date  = classify(s_tdata[13:0], s_tdata[17:14], s_tdata[22:18]);
		q_item.end_date    = classify(s_tdata[36:23], s_tdata[40:37], s_tdata[45:41]);
		q_item.include_end = s_tdata[46];
	end

endmodule

// ===== design/ddd_queue.sv =====
// Small FIFO of classified requests between front and back end.
module ddd_queue #(
	parameter int DEPTH = ddd_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ddd_pkg::ddd_item_t push_item,
	output logic               full,
	input  logic               pop,
	output logic               empty,
	output ddd_pkg::ddd_item_t head
);
	import ddd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	ddd_item_t          mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/ddd_back.sv =====
// Back end: serial day numbers of both dates, difference, saturation, result register.
module ddd_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  ddd_pkg::ddd_item_t          q_head,
	output logic                        q_pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [ddd_pkg::COUNT_W-1:0] out_count,
	output logic                        out_invalid
);
	import ddd_pkg::*;

	typedef enum logic [2:0] {B_IDLE, B_MUL, B_DIV, B_SER, B_DIFF} state_t;

	function automatic logic [8:0] month_before(input logic [MONTH_W-1:0] m);
		logic [8:0] n;
		case (m)
			4'd1:    n = 9'd0;
			4'd2:    n = 9'd31;
			4'd3:    n = 9'd59;
			4'd4:    n = 9'd90;
			4'd5:    n = 9'd120;
			4'd6:    n = 9'd151;
			4'd7:    n = 9'd181;
			4'd8:    n = 9'd212;
			4'd9:    n = 9'd243;
			4'd10:   n = 9'd273;
			4'd11:   n = 9'd304;
			4'd12:   n = 9'd334;
			default: n = 9'd0;
		endcase
		return n;
	endfunction

	state_t               state_q;
	logic                 sel_end_q;
	logic                 out_valid_q;
	logic [COUNT_W-1:0]   out_count_q;
	logic                 out_invalid_q;

	ddd_item_t            item_q;
	logic [YEAR_W-1:0]    y_q;
	logic [PROD_W-1:0]    prod_q;
	logic [Q100_W-1:0]    q100_q;
	logic [R100_W-1:0]    r100_q;
	logic [SERIAL_W-1:0]  ser_a_q;
	logic [SERIAL_W-1:0]  ser_b_q;
	logic                 leap_bad_q;

	ddd_date_t            cur;
	logic [PROD_W-1:0]    prod_next;
	logic [Q100_W-1:0]    q0;
	logic [YEAR_W-1:0]    qm;
	logic [YEAR_W-1:0]    r0;
	logic [Q100_W-1:0]    q_fix;
	logic [R100_W-1:0]    r_fix;
	logic                 leap;
	logic [Q100_W-1:0]    c100;
	logic [Q100_W:0]      c100p3;
	logic [YEAR_W:0]      yp3;
	logic [SERIAL_W-1:0]  serial;
	logic                 leap_bad;
	logic [SERIAL_W-1:0]  diff;
	logic [SERIAL_W:0]    total;
	logic [COUNT_W-1:0]   count_next;
	logic                 invalid_next;
	logic                 out_free;

	assign q_pop       = (state_q == B_IDLE) && !q_empty;
	assign out_valid   = out_valid_q;
	assign out_count   = out_count_q;
	assign out_invalid = out_invalid_q;
	assign out_free    = !out_valid_q || out_ready;

	always_comb begin
		cur       = sel_end_q ? item_q.end_date : item_q.start_date;
		prod_next = PROD_W'(cur.year) * PROD_W'(RECIP_100);

		// reciprocal quotient is low by at most one; fix with one compare
		q0 = prod_q[PROD_W-1:RECIP_SHIFT];
		qm = YEAR_W'(q0) * YEAR_W'(100);
		r0 = y_q - qm;
		if (r0 >= YEAR_W'(100)) begin
			q_fix = q0 + 1'b1;
			r_fix = R100_W'(r0 - YEAR_W'(100));
		end else begin
			q_fix = q0;
			r_fix = R100_W'(r0);
		end

		// days before Jan 1 of y: 365y + ceil(y/4) - ceil(y/100) + ceil(y/400)
		leap   = (y_q[1:0] == 2'b00) && ((r100_q != '0) || (q100_q[1:0] == 2'b00));
		c100   = q100_q + Q100_W'(r100_q != '0);
		c100p3 = {1'b0, c100} + (Q100_W + 1)'(3);
		yp3    = {1'b0, y_q} + (YEAR_W + 1)'(3);
		serial = SERIAL_W'(y_q) * SERIAL_W'(365)
			+ SERIAL_W'(yp3[YEAR_W:2])
			- SERIAL_W'(c100)
			+ SERIAL_W'(c100p3[Q100_W:2])
			+ SERIAL_W'(month_before(cur.month))
			+ SERIAL_W'(leap && (cur.month > MONTH_FEB))
			+ SERIAL_W'(cur.day)
			- SERIAL_W'(1);
		leap_bad = cur.feb29 && !leap;

		diff  = (ser_a_q < ser_b_q) ? (ser_b_q - ser_a_q) : '0;
		total = {1'b0, diff} + (SERIAL_W + 1)'(item_q.include_end);
		invalid_next = !item_q.start_date.ok || !item_q.end_date.ok || leap_bad_q;
		if (invalid_next) begin
			count_next = '0;
		end else if (total > (SERIAL_W + 1)'(COUNT_MAX)) begin
			count_next = COUNT_MAX;
		end else begin
			count_next = total[COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= B_IDLE;
			sel_end_q     <= 1'b0;
			out_valid_q   <= 1'b0;
			out_count_q   <= '0;
			out_invalid_q <= 1'b0;
		end else begin
			// the result step reloads the register itself when it is freed
			if (out_valid_q && out_ready && (state_q != B_DIFF)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						sel_end_q <= 1'b0;
						state_q   <= B_MUL;
					end
				end
				B_MUL: begin
					state_q <= B_DIV;
				end
				B_DIV: begin
					state_q <= B_SER;
				end
				B_SER: begin
					if (sel_end_q) begin
						state_q <= B_DIFF;
					end else begin
						sel_end_q <= 1'b1;
						state_q   <= B_MUL;
					end
				end
				B_DIFF: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						out_count_q   <= count_next;
						out_invalid_q <= invalid_next;
						state_q       <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_head;
		end
		if (state_q == B_MUL) begin
			y_q    <= cur.year;
			prod_q <= prod_next;
		end
		if (state_q == B_DIV) begin
			q100_q <= q_fix;
			r100_q <= r_fix;
		end
		if (state_q == B_SER) begin
			if (sel_end_q) begin
				ser_b_q    <= serial;
				leap_bad_q <= leap_bad_q || leap_bad;
			end else begin
				ser_a_q    <= serial;
				leap_bad_q <= leap_bad;
			end
		end
	end

endmodule

// ===== design/date_difference_days_core.sv =====
// Top level of the Gregorian date difference core.
//
//   channel | direction | tdata (low bit up)                        | tuser
//   s_*     | in        | start_year, start_month, start_day,       | -
//           |           | end_year, end_month, end_day, include_end |
//   m_*     | out       | day_count                                 | date_invalid
//
// In the back end each request takes a load step, two passes through the shared
// divide-by-100 and serial-day unit (multiply, divide and serial steps), and a result step.
// The front end and the request queue keep accepting while the back end works.
// A result waits in the output register; while m_tready stalls, the next request
// waits in the result step, and s_tready drops once the queue is full.
// Reset clears queue and state at once.
module date_difference_days_core #(
	parameter int QUEUE_DEPTH = ddd_pkg::QUEUE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// start_year[13:0], start_month[17:14], start_day[22:18], end_year[36:23],
	// end_month[40:37], end_day[45:41], include_end[46], zero[47]
	input  logic [ddd_pkg::IN_DATA_W-1:0]   s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// day_count[21:0], zero[23:22]
	output logic [ddd_pkg::OUT_DATA_W-1:0]  m_tdata,
	// date_invalid[0]
	output logic                            m_tuser
);
	import ddd_pkg::*;

	logic               q_full;
	logic               q_empty;
	logic               q_push;
	logic               q_pop;
	ddd_item_t          q_item;
	ddd_item_t          q_head;
	logic [COUNT_W-1:0] day_count;

	ddd_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (q_item)
	);

	ddd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	ddd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_count   (day_count),
		.out_invalid (m_tuser)
	);

	assign m_tdata = {(OUT_DATA_W - COUNT_W)'(0), day_count};

endmodule

// ===== design/ddd_checker.sv =====
// Port-level checks for the date difference core, bound to the top level.
module ddd_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [ddd_pkg::OUT_DATA_W-1:0]  m_tdata,
	input logic                            m_tuser
);
	import ddd_pkg::*;

	logic       in_acc;
	logic       out_acc;
	logic [7:0] pend_q;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	// requests accepted and not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			case ({in_acc, out_acc})
				2'b10:   pend_q <= pend_q + 1'b1;
				2'b01:   pend_q <= pend_q - 1'b1;
				default: pend_q <= pend_q;
			endcase
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[COUNT_W-1:0] == '0)
		else $error("invalid date with nonzero count");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != '0)
		else $error("result without a pending request");

	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && pend_q == '0 && !m_tvalid |=> !m_tvalid)
		else $error("result one cycle after request");

endmodule

bind date_difference_days_core ddd_checker u_ddd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
